[hw/rtl/tea_pkg.sv]
// ----------------------------------------------------------------------------
// tea_pkg
// shared types, constants and the round mixing function of the tea engine
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int          TEA_ROUNDS    = 32;
    localparam logic [31:0] TEA_DELTA     = 32'h9E37_79B9;
    localparam int          TEA_CFG_IDX_W = 8;

    localparam logic [31:0] KEY0_RST = 32'hDEAD_BEEF;
    localparam logic [31:0] KEY1_RST = 32'hCAFE_BABE;
    localparam logic [31:0] KEY2_RST = 32'hFEED_FACE;
    localparam logic [31:0] KEY3_RST = 32'hC0DE_FEED;

    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY0 = TEA_CFG_IDX_W'(0);
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY1 = TEA_CFG_IDX_W'(1);
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY2 = TEA_CFG_IDX_W'(2);
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY3 = TEA_CFG_IDX_W'(3);

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    typedef struct packed {
        logic        valid;
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
    } t_stage;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

endpackage

[hw/rtl/tea_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// tea_block_cipher_unit
// pipelined tea engine, one half round per cell, one block per clock
// ----------------------------------------------------------------------------
//  channel   direction  ports                                      handshake
//  command   in         i_start, o_busy, i_op, i_word_*            start & !busy
//  result    out        o_done, o_out_first, o_out_second          done, one cycle
//  config    in         i_cfg_valid, o_cfg_ready, i_cfg_index,     valid & ready
//                       i_cfg_wdata
//
//  each half round is one registered cell
//  a new word is taken every cycle; o_busy stays low
//  synchronous reset clears all pipeline valid bits and loads the reset keys
//  the receiver cannot stall; each result shows for exactly one cycle
// ----------------------------------------------------------------------------
module tea_block_cipher_unit #(
    parameter int ROUNDS = tea_pkg::TEA_ROUNDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_op,
    input  logic [31:0]                       i_word_first,
    input  logic [31:0]                       i_word_second,
    output logic                              o_done,
    output logic [31:0]                       o_out_first,
    output logic [31:0]                       o_out_second,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tea_pkg::TEA_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                       i_cfg_wdata
);
    import tea_pkg::*;

    localparam int NSTAGE = 2 * ROUNDS;

    t_key   r_key;
    t_stage w_pipe [0:NSTAGE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.k0 <= KEY0_RST;
            r_key.k1 <= KEY1_RST;
            r_key.k2 <= KEY2_RST;
            r_key.k3 <= KEY3_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY0: r_key.k0 <= i_cfg_wdata;
                CFG_KEY1: r_key.k1 <= i_cfg_wdata;
                CFG_KEY2: r_key.k2 <= i_cfg_wdata;
                CFG_KEY3: r_key.k3 <= i_cfg_wdata;
                default:  ;
            endcase
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_pipe[0].valid = i_start && !o_busy;
        w_pipe[0].op    = t_op'(i_op);
        w_pipe[0].a     = i_word_first;
        w_pipe[0].b     = i_word_second;
    end

    for (genvar k = 0; k < NSTAGE; k++) begin : g_cell
        tea_round_cell #(
            .P_ROUNDS (ROUNDS),
            .P_ROUND  (k / 2),
            .P_HALF   (k % 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_stage (w_pipe[k]),
            .o_stage (w_pipe[k+1])
        );
    end

    assign o_done       = w_pipe[NSTAGE].valid;
    assign o_out_first  = w_pipe[NSTAGE].a;
    assign o_out_second = w_pipe[NSTAGE].b;

    a_done_has_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, NSTAGE))
        else $error("result word without a command word");

    a_reset_clears : assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

    a_key0_write : assert property (@(posedge i_clk)
        (i_rst_n && i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_KEY0 && $past(i_rst_n))
        |=> (!i_rst_n || r_key.k0 == $past(i_cfg_wdata)))
        else $error("key word 0 not written");

endmodule

[hw/rtl/tea_round_cell.sv]
// ----------------------------------------------------------------------------
// tea_round_cell
// one half round of the cipher, registered, handing its word to the next cell
// ----------------------------------------------------------------------------
module tea_round_cell #(
    parameter int P_ROUNDS = 32,
    parameter int P_ROUND  = 0,
    parameter int P_HALF   = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tea_pkg::t_key   i_key,
    input  tea_pkg::t_stage i_stage,
    output tea_pkg::t_stage o_stage
);
    import tea_pkg::*;

    localparam logic [63:0] ENC_PROD = 64'(TEA_DELTA) * 64'(P_ROUND + 1);
    localparam logic [63:0] DEC_PROD = 64'(TEA_DELTA) * 64'(P_ROUNDS - P_ROUND);
    localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
    localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];

    t_stage      r_stage;
    t_stage      n_stage;
    logic        w_upd_a;
    logic [31:0] w_src;
    logic [31:0] w_dst;
    logic [31:0] w_sum;
    logic [31:0] w_ka;
    logic [31:0] w_kb;
    logic [31:0] w_mix;
    logic [31:0] w_res;

    always_comb begin
        // first half of encrypt and second half of decrypt update the a half
        if (P_HALF == 0) begin
            w_upd_a = (i_stage.op == OP_ENCRYPT);
        end else begin
            w_upd_a = (i_stage.op == OP_DECRYPT);
        end
        w_src = w_upd_a ? i_stage.b : i_stage.a;
        w_dst = w_upd_a ? i_stage.a : i_stage.b;
        w_ka  = w_upd_a ? i_key.k0 : i_key.k2;
        w_kb  = w_upd_a ? i_key.k1 : i_key.k3;
        w_sum = (i_stage.op == OP_ENCRYPT) ? ENC_SUM : DEC_SUM;
        w_mix = tea_mix(w_src, w_sum, w_ka, w_kb);
        w_res = (i_stage.op == OP_ENCRYPT) ? (w_dst + w_mix) : (w_dst - w_mix);

        n_stage = i_stage;
        if (w_upd_a) begin
            n_stage.a = w_res;
        end else begin
            n_stage.b = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.op <= n_stage.op;
        r_stage.a  <= n_stage.a;
        r_stage.b  <= n_stage.b;
    end

    assign o_stage = r_stage;

endmodule
